### sv/gcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared constants, register indexes and helpers for the grid corner detector.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int MAX_WIDTH         = 1024;
  localparam int ROW_LIMIT         = 1024;
  localparam int MAX_CELLS_PER_ROW = 171;
  localparam int BORDER            = 5;
  localparam int MIN_CELL          = 6;

  localparam int LINE_AW   = $clog2(MAX_WIDTH);
  localparam int CELL_AW   = $clog2(MAX_CELLS_PER_ROW);
  localparam int POS_W     = 10;
  localparam int DIM_W     = 11;
  localparam int CELL_W    = 7;
  localparam int SCORE_W   = 20;
  localparam int RECIP_W   = 14;
  localparam int RECIP_SH  = 16;
  localparam int PROD_W    = POS_W + RECIP_W;

  // luminance weights, Q8
  localparam int LUM_WR  = 54;
  localparam int LUM_WG  = 183;
  localparam int LUM_WB  = 19;
  localparam int LUM_RND = 128;

  // register reset values
  localparam int RST_WIDTH     = 640;
  localparam int RST_HEIGHT    = 480;
  localparam int RST_CELL      = 16;
  localparam int RST_MIN_SCORE = 1000;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH     = 2'd0,
    CFG_HEIGHT    = 2'd1,
    CFG_CELL      = 2'd2,
    CFG_MIN_SCORE = 2'd3
  } cfg_idx_t;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  // ceil(2^16 / c); with an operand below 1024 the quotient (v * r) >> 16 is exact
  function automatic logic [RECIP_W-1:0] cell_recip(input logic [CELL_W-1:0] c);
    case (c)
      7'd6:  cell_recip = 14'd10923;
      7'd7:  cell_recip = 14'd9363;
      7'd8:  cell_recip = 14'd8192;
      7'd9:  cell_recip = 14'd7282;
      7'd10: cell_recip = 14'd6554;
      7'd11: cell_recip = 14'd5958;
      7'd12: cell_recip = 14'd5462;
      7'd13: cell_recip = 14'd5042;
      7'd14: cell_recip = 14'd4682;
      7'd15: cell_recip = 14'd4370;
      7'd16: cell_recip = 14'd4096;
      7'd17: cell_recip = 14'd3856;
      7'd18: cell_recip = 14'd3641;
      7'd19: cell_recip = 14'd3450;
      7'd20: cell_recip = 14'd3277;
      7'd21: cell_recip = 14'd3121;
      7'd22: cell_recip = 14'd2979;
      7'd23: cell_recip = 14'd2850;
      7'd24: cell_recip = 14'd2731;
      7'd25: cell_recip = 14'd2622;
      7'd26: cell_recip = 14'd2521;
      7'd27: cell_recip = 14'd2428;
      7'd28: cell_recip = 14'd2341;
      7'd29: cell_recip = 14'd2260;
      7'd30: cell_recip = 14'd2185;
      7'd31: cell_recip = 14'd2115;
      7'd32: cell_recip = 14'd2048;
      7'd33: cell_recip = 14'd1986;
      7'd34: cell_recip = 14'd1928;
      7'd35: cell_recip = 14'd1873;
      7'd36: cell_recip = 14'd1821;
      7'd37: cell_recip = 14'd1772;
      7'd38: cell_recip = 14'd1725;
      7'd39: cell_recip = 14'd1681;
      7'd40: cell_recip = 14'd1639;
      7'd41: cell_recip = 14'd1599;
      7'd42: cell_recip = 14'd1561;
      7'd43: cell_recip = 14'd1525;
      7'd44: cell_recip = 14'd1490;
      7'd45: cell_recip = 14'd1457;
      7'd46: cell_recip = 14'd1425;
      7'd47: cell_recip = 14'd1395;
      7'd48: cell_recip = 14'd1366;
      7'd49: cell_recip = 14'd1338;
      7'd50: cell_recip = 14'd1311;
      7'd51: cell_recip = 14'd1286;
      7'd52: cell_recip = 14'd1261;
      7'd53: cell_recip = 14'd1237;
      7'd54: cell_recip = 14'd1214;
      7'd55: cell_recip = 14'd1192;
      7'd56: cell_recip = 14'd1171;
      7'd57: cell_recip = 14'd1150;
      7'd58: cell_recip = 14'd1130;
      7'd59: cell_recip = 14'd1111;
      7'd60: cell_recip = 14'd1093;
      7'd61: cell_recip = 14'd1075;
      7'd62: cell_recip = 14'd1058;
      7'd63: cell_recip = 14'd1041;
      7'd64: cell_recip = 14'd1024;
      default: cell_recip = 14'd10923;
    endcase
  endfunction

endpackage

### sv/gcd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // same-address read returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/grid_corner_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_corner_detector
// Streaming gradient corner detector with per-cell maximum selection.
// Throughput: one pixel per clock while in_stall is low, given by the pipeline and
//   the separate read and write ports of the line store and the cell store.
// The pixel closing a cell passes s1_r to s5_r and out_r before its result shows on out_*.
// Reset: sync, active low. A line store clearing pass over all 1024 words follows
//   reset, with in_stall high; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module grid_corner_detector
  import gcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  input  logic                  in_frame_start,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [POS_W-1:0]      out_corner_x,
  output logic [POS_W-1:0]      out_corner_y,
  output logic [SCORE_W-1:0]    out_corner_strength,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [7:0]       lum;
    logic             fwd;
  } s1_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] ox;
    logic [POS_W-1:0] oy;
    logic             at_right;
    logic             at_bottom;
  } s2_t;

  typedef struct packed {
    logic [7:0]        ad_gx;
    logic [7:0]        ad_gy;
    logic [7:0]        ad_d1;
    logic [7:0]        ad_d2;
    logic [PROD_W-1:0] prod_x;
    logic [PROD_W-1:0] prod_y;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [POS_W-1:0]  ox;
    logic [POS_W-1:0]  oy;
    logic              at_right;
    logic              at_bottom;
  } s3_t;

  typedef struct packed {
    logic [15:0]      sq_gx;
    logic [15:0]      sq_gy;
    logic [15:0]      sq_d1;
    logic [15:0]      sq_d2;
    logic [7:0]       qx;
    logic [14:0]      mul_x;
    logic [14:0]      mul_y;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] ox;
    logic [POS_W-1:0] oy;
    logic             at_right;
    logic             at_bottom;
  } s4_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
  } cell_t;

  typedef struct packed {
    logic [CELL_AW-1:0] ci;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [SCORE_W-1:0] score;
    logic               first;
    logic               last;
    logic               fwd;
  } s5_t;

  // ---------------- configuration ----------------
  logic [DIM_W-1:0]   fw_r, fh_r;
  logic [CELL_W-1:0]  cs_r;
  logic [SCORE_W-1:0] ms_r;
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [CELL_W-1:0]  cell_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= DIM_W'(RST_WIDTH);
      fh_r <= DIM_W'(RST_HEIGHT);
      cs_r <= CELL_W'(RST_CELL);
      ms_r <= SCORE_W'(RST_MIN_SCORE);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH:     fw_r <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT:    fh_r <= cfg_data[DIM_W-1:0];
        CFG_CELL:      cs_r <= cfg_data[CELL_W-1:0];
        CFG_MIN_SCORE: ms_r <= cfg_data[SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fw_r > DIM_W'(MAX_WIDTH))   w_eff = DIM_W'(MAX_WIDTH);
    else if (fw_r == '0)           w_eff = DIM_W'(1);
    else                           w_eff = fw_r;
    if (fh_r > DIM_W'(ROW_LIMIT))   h_eff = DIM_W'(ROW_LIMIT);
    else if (fh_r == '0)           h_eff = DIM_W'(1);
    else                           h_eff = fh_r;
    cell_eff = (cs_r < CELL_W'(MIN_CELL)) ? CELL_W'(MIN_CELL) : cs_r;
  end

  // ---------------- flow control ----------------
  logic clr_active_r;
  logic [LINE_AW-1:0] clr_addr_r;
  logic skid_valid_r, out_valid_r;
  logic en, accept;

  assign en       = !skid_valid_r;
  assign in_stall = clr_active_r || skid_valid_r;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == LINE_AW'(MAX_WIDTH - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // ---------------- stage 0: position, luminance, line store read ----------------
  logic [POS_W-1:0] col_r, row_r, col_cur, row_cur, col_nxt, row_nxt;
  logic [DIM_W-1:0] col_inc, row_ext;
  logic [15:0]      lum_sum;
  logic [7:0]       lum;

  assign col_cur = in_frame_start ? '0 : col_r;
  assign row_cur = in_frame_start ? '0 : row_r;
  assign lum_sum = 16'(LUM_WR) * 16'(in_red) + 16'(LUM_WG) * 16'(in_green)
                 + 16'(LUM_WB) * 16'(in_blue) + 16'(LUM_RND);
  assign lum     = lum_sum[15:8];
  assign col_inc = {1'b0, col_cur} + DIM_W'(1);

  always_comb begin
    col_nxt = col_inc[POS_W-1:0];
    row_ext = {1'b0, row_cur};
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_ext = {1'b0, row_cur} + DIM_W'(1);
    end
    row_nxt = (row_ext >= h_eff) ? '0 : row_ext[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line store word: [15:8] two rows above, [7:0] one row above
  logic        s1_valid_r;
  s1_t         s1_r;
  logic [15:0] line_rdata, line_word, line_wdata, line_fwd_r, line_din;
  logic        line_we;
  logic [LINE_AW-1:0] line_waddr;
  logic [7:0]  up1, up2;

  assign line_word  = s1_r.fwd ? line_fwd_r : line_rdata;
  assign up1        = line_word[7:0];
  assign up2        = line_word[15:8];
  assign line_wdata = {up1, s1_r.lum};
  assign line_we    = clr_active_r || (en && s1_valid_r);
  assign line_waddr = clr_active_r ? clr_addr_r : s1_r.col;
  assign line_din   = clr_active_r ? '0 : line_wdata;

  gcd_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_din),
    .re    (accept),
    .raddr (col_cur),
    .rdata (line_rdata)
  );

  // ---------------- stage 1: window, border test ----------------
  logic [7:0] win_r [9];
  logic [POS_W-1:0] x1, y1;
  logic scored1;

  assign x1 = s1_r.col - POS_W'(1);
  assign y1 = s1_r.row - POS_W'(1);
  assign scored1 = s1_valid_r && (s1_r.col != '0) && (s1_r.row != '0)
                && (x1 >= POS_W'(BORDER)) && (({1'b0, x1} + DIM_W'(BORDER)) < w_eff)
                && (y1 >= POS_W'(BORDER)) && (({1'b0, y1} + DIM_W'(BORDER)) < h_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else if (en && s1_valid_r) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3]     <= win_r[r*3 + 1];
        win_r[r*3 + 1] <= win_r[r*3 + 2];
      end
      win_r[2] <= up2;
      win_r[5] <= up1;
      win_r[8] <= s1_r.lum;
    end
  end

  // ---------------- stage 2: gradients, cell quotient ----------------
  logic s2_valid_r;
  s2_t  s2_r;
  logic [RECIP_W-1:0] recip;

  assign recip = cell_recip(cell_eff);

  // ---------------- stage 3: squares, quotient back-multiply ----------------
  logic s3_valid_r;
  s3_t  s3_r;
  logic [7:0] qx3, qy3;

  assign qx3 = s3_r.prod_x[RECIP_SH +: 8];
  assign qy3 = s3_r.prod_y[RECIP_SH +: 8];

  // ---------------- stage 4: score, remainders, cell store read ----------------
  logic s4_valid_r;
  s4_t  s4_r;
  logic [SCORE_W-1:0] score4;
  logic [POS_W-1:0]   remx, remy, cell_last;
  logic               in_range4;

  assign score4 = ((SCORE_W'(s4_r.sq_gx) + SCORE_W'(s4_r.sq_gy)) << 2)
                + SCORE_W'(s4_r.sq_d1) + SCORE_W'(s4_r.sq_d2);
  assign remx      = s4_r.ox - s4_r.mul_x[POS_W-1:0];
  assign remy      = s4_r.oy - s4_r.mul_y[POS_W-1:0];
  assign cell_last = POS_W'(cell_eff) - POS_W'(1);
  assign in_range4 = s4_r.qx < 8'(MAX_CELLS_PER_ROW);

  // ---------------- stage 5: cell update, emit decision ----------------
  logic  s5_valid_r;
  s5_t   s5_r;
  cell_t cell_rdata, cell_old, cell_base, cell_new, cell_fwd_r;
  logic [MAX_CELLS_PER_ROW-1:0] cell_vld_r;
  logic  cell_we, res_valid, res_fire;

  always_comb begin
    if (s5_r.fwd)                 cell_old = cell_fwd_r;
    else if (cell_vld_r[s5_r.ci]) cell_old = cell_rdata;
    else                          cell_old = '0;
    cell_base = s5_r.first ? '0 : cell_old;
    cell_new  = cell_base;
    if (s5_r.score > cell_base.score) begin
      cell_new = '{score: s5_r.score, col: s5_r.x, row: s5_r.y};
    end
  end

  assign cell_we   = en && s5_valid_r;
  assign res_valid = s5_valid_r && s5_r.last && (cell_new.score >= ms_r);
  assign res_fire  = en && res_valid;

  gcd_ram #(.WIDTH($bits(cell_t)), .DEPTH(MAX_CELLS_PER_ROW)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (s5_r.ci),
    .wdata (cell_new),
    .re    (en),
    .raddr (s4_r.qx[CELL_AW-1:0]),
    .rdata (cell_rdata)
  );

  // ---------------- pipeline registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      cell_vld_r <= '0;
    end else if (en) begin
      s1_valid_r <= accept;
      s2_valid_r <= scored1;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r && in_range4;
      if (s5_valid_r) begin
        cell_vld_r[s5_r.ci] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r.col   <= col_cur;
      s1_r.row   <= row_cur;
      s1_r.lum   <= lum;
      s1_r.fwd   <= s1_valid_r && (s1_r.col == col_cur);
      line_fwd_r <= line_wdata;

      s2_r.x         <= x1;
      s2_r.y         <= y1;
      s2_r.ox        <= x1 - POS_W'(BORDER);
      s2_r.oy        <= y1 - POS_W'(BORDER);
      s2_r.at_right  <= ({1'b0, x1} + DIM_W'(BORDER + 1)) == w_eff;
      s2_r.at_bottom <= ({1'b0, y1} + DIM_W'(BORDER + 1)) == h_eff;

      s3_r.ad_gx     <= abs_diff(win_r[5], win_r[3]);
      s3_r.ad_gy     <= abs_diff(win_r[7], win_r[1]);
      s3_r.ad_d1     <= abs_diff(win_r[8], win_r[0]);
      s3_r.ad_d2     <= abs_diff(win_r[2], win_r[6]);
      s3_r.prod_x    <= PROD_W'(s2_r.ox) * PROD_W'(recip);
      s3_r.prod_y    <= PROD_W'(s2_r.oy) * PROD_W'(recip);
      s3_r.x         <= s2_r.x;
      s3_r.y         <= s2_r.y;
      s3_r.ox        <= s2_r.ox;
      s3_r.oy        <= s2_r.oy;
      s3_r.at_right  <= s2_r.at_right;
      s3_r.at_bottom <= s2_r.at_bottom;

      s4_r.sq_gx     <= 16'(s3_r.ad_gx) * 16'(s3_r.ad_gx);
      s4_r.sq_gy     <= 16'(s3_r.ad_gy) * 16'(s3_r.ad_gy);
      s4_r.sq_d1     <= 16'(s3_r.ad_d1) * 16'(s3_r.ad_d1);
      s4_r.sq_d2     <= 16'(s3_r.ad_d2) * 16'(s3_r.ad_d2);
      s4_r.qx        <= qx3;
      s4_r.mul_x     <= 15'(qx3) * 15'(cell_eff);
      s4_r.mul_y     <= 15'(qy3) * 15'(cell_eff);
      s4_r.x         <= s3_r.x;
      s4_r.y         <= s3_r.y;
      s4_r.ox        <= s3_r.ox;
      s4_r.oy        <= s3_r.oy;
      s4_r.at_right  <= s3_r.at_right;
      s4_r.at_bottom <= s3_r.at_bottom;

      s5_r.ci    <= s4_r.qx[CELL_AW-1:0];
      s5_r.x     <= s4_r.x;
      s5_r.y     <= s4_r.y;
      s5_r.score <= score4;
      s5_r.first <= (remx == '0) && (remy == '0);
      s5_r.last  <= ((remx == cell_last) || s4_r.at_right)
                 && ((remy == cell_last) || s4_r.at_bottom);
      // cell written this cycle is read back stale by the RAM
      s5_r.fwd   <= s5_valid_r && (s5_r.ci == s4_r.qx[CELL_AW-1:0]);
      cell_fwd_r <= cell_new;
    end
  end

  // ---------------- output register with skid ----------------
  cell_t out_r, skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        if (skid_valid_r) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end else if (res_fire) begin
          out_r <= cell_new;
        end else begin
          out_valid_r <= 1'b0;
        end
      end else if (!out_valid_r) begin
        if (res_fire) begin
          out_r       <= cell_new;
          out_valid_r <= 1'b1;
        end
      end else if (res_fire) begin
        skid_r       <= cell_new;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_corner_x        = out_r.col;
  assign out_corner_y        = out_r.row;
  assign out_corner_strength = out_r.score;

  // ---------------- assertions ----------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while the output register is empty");

  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> in_stall)
    else $error("input open during line store clearing");

  a_stalled_result_parked: assert property (@(posedge clk) disable iff (!rst_n)
    (res_fire && out_valid_r && out_stall) |=> skid_valid_r)
    else $error("result lost while output stalled");

  a_frozen_when_skid_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> (!cell_we && !res_fire))
    else $error("pipeline advanced with skid full");

endmodule
